// File: src/plist_pkg.sv
// Package with the shared constants, types and helper functions of the positional list store.
`default_nettype none
package plist_pkg;

    localparam int DEPTH      = 32;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int ELEM_W   = 32;
    localparam int OCC_W    = 6;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 3;
    localparam int M_PAD_W   = M_TDATA_W - ELEM_W - OCC_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_BACK  = 3'd4,
        CMD_DEL_AT    = 3'd5,
        CMD_DUMP      = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL,
        CELL_ROT
    } cell_op_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_DUMP
    } fsm_t;

    typedef struct packed {
        cell_op_t              op;
        logic [IDX_W-1:0]      sel;
        logic [DATA_WIDTH-1:0] din;
    } cell_ctl_t;

    // Keeps the low bits of the input value that fit in one stored element.
    function automatic logic [DATA_WIDTH-1:0] to_data(input logic [VALUE_W-1:0] v);
        logic [DATA_WIDTH-1:0] r;
        r = '0;
        for (int b = 0; b < DATA_WIDTH; b++) begin
            if (b < VALUE_W) begin
                r[b] = v[b];
            end
        end
        return r;
    endfunction

    // Sign-extends or truncates a stored element to the width of the result field.
    function automatic logic [ELEM_W-1:0] to_element(input logic [DATA_WIDTH-1:0] d);
        logic [ELEM_W-1:0] r;
        r = '0;
        for (int b = 0; b < ELEM_W; b++) begin
            if (b < DATA_WIDTH) begin
                r[b] = d[b];
            end else begin
                r[b] = d[DATA_WIDTH-1];
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: src/plist_cell.sv
// One storage cell of the list chain, holding a single element.
`default_nettype none
module plist_cell (
    input  wire logic                            aclk,
    input  wire plist_pkg::cell_ctl_t            ctl,
    input  wire logic [plist_pkg::IDX_W-1:0]      idx,
    input  wire logic [plist_pkg::DATA_WIDTH-1:0] left,
    input  wire logic [plist_pkg::DATA_WIDTH-1:0] right,
    input  wire logic [plist_pkg::DATA_WIDTH-1:0] head,
    output logic      [plist_pkg::DATA_WIDTH-1:0] data
);

    logic [plist_pkg::DATA_WIDTH-1:0] data_reg;
    logic [plist_pkg::DATA_WIDTH-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        unique case (ctl.op)
            plist_pkg::CELL_HOLD: begin
                data_next = data_reg;
            end
            plist_pkg::CELL_INS: begin
                if (idx > ctl.sel) begin
                    data_next = left;
                end else if (idx == ctl.sel) begin
                    data_next = ctl.din;
                end
            end
            plist_pkg::CELL_DEL: begin
                if (idx >= ctl.sel) begin
                    data_next = right;
                end
            end
            plist_pkg::CELL_ROT: begin
                if (idx == ctl.sel) begin
                    data_next = head;
                end else if (idx < ctl.sel) begin
                    data_next = right;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
`default_nettype wire

// File: src/plist_chain.sv
// Row of list cells, each linked to its neighbors, with the front cell as the read port.
`default_nettype none
module plist_chain (
    input  wire logic                            aclk,
    input  wire plist_pkg::cell_ctl_t            ctl,
    output logic      [plist_pkg::DATA_WIDTH-1:0] head
);

    logic [plist_pkg::DATA_WIDTH-1:0] cell_data [plist_pkg::DEPTH];

    for (genvar g = 0; g < plist_pkg::DEPTH; g++) begin : g_cell
        logic [plist_pkg::DATA_WIDTH-1:0] left_w;
        logic [plist_pkg::DATA_WIDTH-1:0] right_w;

        if (g == 0) begin : g_first
            assign left_w = ctl.din;
        end else begin : g_inner_l
            assign left_w = cell_data[g-1];
        end

        if (g == plist_pkg::DEPTH - 1) begin : g_last
            assign right_w = cell_data[g];
        end else begin : g_inner_r
            assign right_w = cell_data[g+1];
        end

        plist_cell u_cell (
            .aclk  (aclk),
            .ctl   (ctl),
            .idx   (plist_pkg::IDX_W'(g)),
            .left  (left_w),
            .right (right_w),
            .head  (cell_data[0]),
            .data  (cell_data[g])
        );
    end

    assign head = cell_data[0];

endmodule
`default_nettype wire

// File: src/positional_list_store.sv
// Top level of the positional list store: command decode, sequencing and result register.
// Every edit command is decoded when taken, a legal one is applied to the cell chain, and it gives its
// result the cycle after the transfer; one command per cycle while results are taken.
// A dump of N elements (N > 0) gives N results; while results are taken, the chain rotates by one
// cell per cycle and the front cell is read out each time, so its length follows the occupancy.
// Reset clears the element count, the sequencer and the result valid flag; the cell
// contents are not reset, as only cells below the count are ever read.
`default_nettype none
module positional_list_store (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // value [31:0], position [39:32]
    input  wire logic [plist_pkg::S_TDATA_W-1:0] s_tdata,
    // command [2:0]
    input  wire logic [plist_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // element [31:0], occupancy [37:32], zero [39:38]
    output logic      [plist_pkg::M_TDATA_W-1:0] m_tdata,
    // element_valid [0], status [2:1]
    output logic      [plist_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                                  m_tlast
);

    plist_pkg::fsm_t                   state_reg, state_next;
    logic [plist_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [plist_pkg::CNT_W-1:0]       remain_reg, remain_next;
    logic                              valid_reg, valid_next;
    logic [plist_pkg::ELEM_W-1:0]      elem_reg, elem_next;
    logic                              ev_reg, ev_next;
    logic [plist_pkg::OCC_W-1:0]       occ_reg, occ_next;
    plist_pkg::status_t                status_reg, status_next;
    logic                              last_reg, last_next;

    plist_pkg::cell_ctl_t              ctl;
    logic [plist_pkg::DATA_WIDTH-1:0]  head;
    logic                              out_free;
    plist_pkg::cmd_t                   cmd;
    logic [plist_pkg::POS_W-1:0]       pos;
    logic [plist_pkg::POS_W:0]         cnt_x;

    assign cmd      = plist_pkg::cmd_t'(s_tuser[plist_pkg::CMD_W-1:0]);
    assign pos      = s_tdata[plist_pkg::VALUE_W +: plist_pkg::POS_W];
    assign cnt_x    = (plist_pkg::POS_W + 1)'(count_reg);
    assign out_free = !valid_reg || m_tready;

    plist_chain u_chain (
        .aclk (aclk),
        .ctl  (ctl),
        .head (head)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= plist_pkg::FSM_IDLE;
            count_reg  <= '0;
            remain_reg <= '0;
            valid_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        elem_reg   <= elem_next;
        ev_reg     <= ev_next;
        occ_reg    <= occ_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    always_comb begin
        logic [plist_pkg::POS_W:0] epos;
        logic                      is_ins;
        logic                      load;

        state_next  = state_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        valid_next  = valid_reg && !m_tready;
        elem_next   = elem_reg;
        ev_next     = ev_reg;
        occ_next    = occ_reg;
        status_next = status_reg;
        last_next   = last_reg;
        ctl.op      = plist_pkg::CELL_HOLD;
        ctl.sel     = '0;
        ctl.din     = plist_pkg::to_data(s_tdata[plist_pkg::VALUE_W-1:0]);
        s_tready    = 1'b0;
        epos        = '0;
        is_ins      = 1'b0;
        load        = 1'b0;

        unique case (state_reg)
            plist_pkg::FSM_IDLE: begin
                s_tready = out_free;
                if (s_tvalid && out_free) begin
                    load        = 1'b1;
                    elem_next   = '0;
                    ev_next     = 1'b0;
                    last_next   = 1'b1;
                    status_next = plist_pkg::ST_OK;
                    unique case (cmd)
                        plist_pkg::CMD_INS_FRONT: begin
                            epos   = (plist_pkg::POS_W + 1)'(1);
                            is_ins = 1'b1;
                        end
                        plist_pkg::CMD_INS_BACK: begin
                            epos   = cnt_x + (plist_pkg::POS_W + 1)'(1);
                            is_ins = 1'b1;
                        end
                        plist_pkg::CMD_INS_AT: begin
                            epos   = (plist_pkg::POS_W + 1)'(pos);
                            is_ins = 1'b1;
                        end
                        plist_pkg::CMD_DEL_FRONT: epos = (plist_pkg::POS_W + 1)'(1);
                        plist_pkg::CMD_DEL_BACK:  epos = cnt_x;
                        plist_pkg::CMD_DEL_AT:    epos = (plist_pkg::POS_W + 1)'(pos);
                        plist_pkg::CMD_DUMP: begin
                            if (count_reg != '0) begin
                                load        = 1'b0;
                                state_next  = plist_pkg::FSM_DUMP;
                                remain_next = count_reg;
                            end
                        end
                        default: status_next = plist_pkg::ST_BADPOS;
                    endcase

                    if (is_ins) begin
                        if (epos == '0 || epos > cnt_x + (plist_pkg::POS_W + 1)'(1)) begin
                            status_next = plist_pkg::ST_BADPOS;
                        end else if (count_reg == plist_pkg::CNT_W'(plist_pkg::DEPTH)) begin
                            status_next = plist_pkg::ST_FULL;
                        end else begin
                            ctl.op     = plist_pkg::CELL_INS;
                            ctl.sel    = plist_pkg::IDX_W'(epos - (plist_pkg::POS_W + 1)'(1));
                            count_next = count_reg + plist_pkg::CNT_W'(1);
                        end
                    end else if (cmd == plist_pkg::CMD_DEL_FRONT || cmd == plist_pkg::CMD_DEL_BACK
                                 || cmd == plist_pkg::CMD_DEL_AT) begin
                        if (count_reg == '0) begin
                            status_next = plist_pkg::ST_EMPTY;
                        end else if (epos == '0 || epos > cnt_x) begin
                            status_next = plist_pkg::ST_BADPOS;
                        end else begin
                            ctl.op     = plist_pkg::CELL_DEL;
                            ctl.sel    = plist_pkg::IDX_W'(epos - (plist_pkg::POS_W + 1)'(1));
                            count_next = count_reg - plist_pkg::CNT_W'(1);
                        end
                    end
                end
            end
            plist_pkg::FSM_DUMP: begin
                if (out_free) begin
                    load        = 1'b1;
                    elem_next   = plist_pkg::to_element(head);
                    ev_next     = 1'b1;
                    status_next = plist_pkg::ST_OK;
                    last_next   = (remain_reg == plist_pkg::CNT_W'(1));
                    ctl.op      = plist_pkg::CELL_ROT;
                    ctl.sel     = plist_pkg::IDX_W'(count_reg - plist_pkg::CNT_W'(1));
                    remain_next = remain_reg - plist_pkg::CNT_W'(1);
                    if (remain_reg == plist_pkg::CNT_W'(1)) begin
                        state_next = plist_pkg::FSM_IDLE;
                    end
                end
            end
        endcase

        if (load) begin
            valid_next = 1'b1;
            occ_next   = plist_pkg::OCC_W'(count_next);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{plist_pkg::M_PAD_W{1'b0}}, occ_reg, elem_reg};
    assign m_tuser  = {status_reg, ev_reg};
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire

// File: src/plist_checker.sv
// Port-level checker for the positional list store, bound to the top level.
`default_nettype none
module plist_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [plist_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [plist_pkg::M_TUSER_W-1:0] m_tuser,
    input wire logic                             m_tlast
);

    logic [plist_pkg::OCC_W-1:0] occ;
    assign occ = m_tdata[plist_pkg::ELEM_W +: plist_pkg::OCC_W];

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result transfer changed");

    a_elem_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[2:1] == plist_pkg::ST_OK && occ != '0)
        else $error("element result with bad status or empty occupancy");

    a_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[plist_pkg::ELEM_W-1:0] == '0 && m_tlast)
        else $error("edit result carries data or is not final");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> occ <= plist_pkg::OCC_W'(plist_pkg::DEPTH) && !(s_tvalid && s_tready
                     && m_tuser[0] && !m_tlast))
        else $error("occupancy above depth or command taken during a dump");

endmodule

bind positional_list_store plist_checker u_plist_checker (.*);
`default_nettype wire
